// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the stack instruction unit RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define SIU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define SIU_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/siu_pkg.sv -----
// Package for the stack instruction unit: sizes, command and status codes,
// and the request and result structs. No dependencies.
`default_nettype none

package siu_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_W      = 32;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_DUMP = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_POP  = 3'd3,
    CMD_SWAP = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SWAP_SHORT = 3'd3,
    ST_PUSH_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] data_word;
    status_t            status;
    logic               last_of_run;
  } out_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/siu_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`default_nettype none

module siu_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stack_instruction_unit.sv -----
// Stack instruction unit top level: command sequencer, entry count and result register.
// Depends on siu_pkg, siu_ram and assert_macros.svh.
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+------------------------------------
//  request  | start, busy, in_req      | taken when start high and busy low
//  result   | out_valid, out_rsp       | one-cycle strobe, cannot be stalled
//
// Push, pop and every error case finish in S_IDLE; busy stays low and a new
// request may follow at once. Peek waits in S_PEEK for the registered RAM read.
// Swap steps through S_SWAP_RD, S_SWAP_WR_TOP and S_SWAP_WR_LOW: two reads, then
// two writes through the single RAM. Dump makes one RAM read per entry, top first.
// Reset is synchronous and clears the entry count; stack words are not cleared.
// Results leave through a register in the cycle after they are formed.
`default_nettype none

`include "assert_macros.svh"

module stack_instruction_unit import siu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  output out_rsp_t      out_rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_DUMP,
    S_SWAP_RD,
    S_SWAP_WR_TOP,
    S_SWAP_WR_LOW
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [WORD_W-1:0]  tmp_r, tmp_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_rsp_r, out_rsp_nxt;

  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic [WORD_W-1:0]  rd_data;

  logic [PTR_W-1:0]   top_idx;
  logic [PTR_W-1:0]   ptr_low;
  logic               empty;
  logic               full;
  logic               accept;

  assign top_idx = PTR_W'(cnt_r - CNT_W'(1));
  assign ptr_low = ptr_r - PTR_W'(1);
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(STACK_DEPTH));
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;

  siu_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode the request and step the sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '{data_word: '0, status: ST_OK, last_of_run: 1'b1};
    wr_en         = 1'b0;
    wr_addr       = cnt_r[PTR_W-1:0];
    wr_data       = in_req.push_value;
    rd_en         = 1'b0;
    rd_addr       = top_idx;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req.cmd)
            CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_rsp_nxt.status = ST_PUSH_FULL;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            CMD_POP: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_rsp_nxt.status = ST_POP_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            CMD_PEEK: begin
              if (empty) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = ST_PEEK_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_PEEK;
              end
            end
            CMD_SWAP: begin
              if (cnt_r < CNT_W'(2)) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = ST_SWAP_SHORT;
              end else begin
                rd_en     = 1'b1;
                ptr_nxt   = top_idx;
                state_nxt = S_SWAP_RD;
              end
            end
            CMD_DUMP: begin
              // An empty stack dumps nothing
              if (!empty) begin
                rd_en     = 1'b1;
                ptr_nxt   = top_idx;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              // Drop unused codes
            end
          endcase
        end
      end

      S_PEEK: begin
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.data_word = rd_data;
        state_nxt             = S_IDLE;
      end

      S_DUMP: begin
        // Emit the word read last cycle and, above the bottom entry, fetch the one below it
        out_valid_nxt           = 1'b1;
        out_rsp_nxt.data_word   = rd_data;
        out_rsp_nxt.last_of_run = (ptr_r == '0);
        if (ptr_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_low;
          ptr_nxt = ptr_low;
        end
      end

      S_SWAP_RD: begin
        // Hold the top word, fetch the one below
        tmp_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = ptr_low;
        state_nxt = S_SWAP_WR_TOP;
      end

      S_SWAP_WR_TOP: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_r;
        wr_data   = rd_data;
        state_nxt = S_SWAP_WR_LOW;
      end

      S_SWAP_WR_LOW: begin
        wr_en         = 1'b1;
        wr_addr       = ptr_low;
        wr_data       = tmp_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, entry count and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r     <= ptr_nxt;
    tmp_r     <= tmp_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Checks on the sequencer
  `SIU_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(STACK_DEPTH), "entry count above stack depth")
  `SIU_ASSERT(a_err_zero, (out_valid && out_rsp.status != ST_OK) |-> (out_rsp.data_word == '0), "error result carries data")
  `SIU_ASSERT(a_dump_run, (out_valid && !out_rsp.last_of_run) |=> out_valid, "dump run broken")
  `SIU_ASSERT(a_push_cnt, (accept && in_req.cmd == CMD_PUSH && !full) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)), "push did not grow the stack")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for stack_instruction_unit: drives push, pop, swap, peek and dump
// requests and checks every result against a scoreboard that models the stack.
// Depends on siu_pkg and the stack_instruction_unit RTL.
`default_nettype none

module tb;
  import siu_pkg::*;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam int RUN_ITEMS      = 360;
  localparam int DRAIN_CYCLES   = STACK_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PCT [3]   = '{0, 69, 14};

  // Command codes that the block does not decode
  localparam logic [2:0] FIRST_UNUSED_CMD = 3'd5;
  localparam logic [2:0] LAST_UNUSED_CMD  = 3'd7;

  // Stack model, queue of expected results and mismatch count
  class stack_scoreboard;
    word_t    stack_words [STACK_DEPTH];
    int       depth;
    out_rsp_t pending_rsp [$];
    int       fail_count;

    function new();
      depth      = 0;
      fail_count = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    // Apply one accepted request and queue the results it must produce
    function void note_request(in_req_t req);
      out_rsp_t rsp;
      word_t    held;
      int       k;
      rsp = '{data_word: '0, status: ST_OK, last_of_run: 1'b1};
      case (req.cmd)
        CMD_PUSH: begin
          if (depth >= STACK_DEPTH) begin
            rsp.status = ST_PUSH_FULL;
          end else begin
            stack_words[depth] = req.push_value;
            depth++;
          end
        end
        CMD_DUMP: begin
          for (k = 0; k < depth; k++) begin
            rsp.data_word   = stack_words[depth-1-k];
            rsp.last_of_run = (k == depth - 1);
            pending_rsp.push_back(rsp);
          end
          return;
        end
        CMD_PEEK: begin
          if (depth == 0) rsp.status = ST_PEEK_EMPTY;
          else rsp.data_word = stack_words[depth-1];
        end
        CMD_POP: begin
          if (depth == 0) rsp.status = ST_POP_EMPTY;
          else depth--;
        end
        CMD_SWAP: begin
          if (depth < 2) begin
            rsp.status = ST_SWAP_SHORT;
          end else begin
            held                 = stack_words[depth-1];
            stack_words[depth-1] = stack_words[depth-2];
            stack_words[depth-2] = held;
          end
        end
        default: return;
      endcase
      pending_rsp.push_back(rsp);
    endfunction

    // Compare one result with the oldest expectation, field by field
    task check_result(out_rsp_t got);
      out_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected result data %h status %0d last %0b",
                                  got.data_word, got.status, got.last_of_run));
        return;
      end
      want = pending_rsp.pop_front();
      if (got.data_word !== want.data_word)
        report_mismatch($sformatf("data_word %h, expected %h", got.data_word, want.data_word));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                  got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_rsp_t out_rsp;

  stack_scoreboard sb;
  int              idle_pct;
  int              track_depth;
  int              items_sent;
  int              quiet_cycles;

  always #1 clk = ~clk;

  stack_instruction_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // Record accepted requests first, then check any result on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_req);
      if (out_valid === 1'b1) sb.check_result(out_rsp);
    end
  end

  // Count cycles with no request or result accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("TIMEOUT: no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return word_t'($urandom_range(0, 15));
      3:       return -word_t'($urandom_range(1, 16));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Present one request from a falling edge, with random idle gaps, and hold until taken
  task automatic send_request(cmd_t cmd, word_t value);
    in_req_t req;
    req.cmd        = cmd;
    req.push_value = value;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (cmd)
      CMD_PUSH: if (track_depth < STACK_DEPTH) track_depth++;
      CMD_POP:  if (track_depth > 0) track_depth--;
      default: ;
    endcase
    if (cmd == CMD_PUSH || cmd == CMD_DUMP || cmd == CMD_PEEK || cmd == CMD_POP ||
        cmd == CMD_SWAP)
      items_sent++;
  endtask

  // Hold off until every expected result has arrived and the block has settled
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_unused_codes();
    logic [2:0] code;
    for (code = FIRST_UNUSED_CMD; code <= LAST_UNUSED_CMD && code >= FIRST_UNUSED_CMD;
         code++)
      send_request(cmd_t'(code), random_word());
  endtask

  // Push towards a target depth with the odd peek or swap; overflow when full
  task automatic fill_segment(bit to_full);
    int target;
    target = (to_full || $urandom_range(0, 2) == 0) ? STACK_DEPTH
                                                     : $urandom_range(track_depth, STACK_DEPTH);
    while (track_depth < target) begin
      if ($urandom_range(0, 4) == 0)
        send_request($urandom_range(0, 1) ? CMD_PEEK : CMD_SWAP, random_word());
      else
        send_request(CMD_PUSH, random_word());
    end
    if (target == STACK_DEPTH)
      repeat ($urandom_range(1, 3)) send_request(CMD_PUSH, random_word());
  endtask

  // Pop towards a lower depth; run past empty now and then
  task automatic drain_segment();
    int target;
    target = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, track_depth);
    while (track_depth > target) begin
      if ($urandom_range(0, 5) == 0)
        send_request($urandom_range(0, 1) ? CMD_PEEK : CMD_SWAP, random_word());
      else
        send_request(CMD_POP, random_word());
    end
    if (target == 0) begin
      repeat ($urandom_range(1, 2)) send_request(CMD_POP, random_word());
      send_request($urandom_range(0, 1) ? CMD_PEEK : CMD_SWAP, random_word());
    end
  endtask

  // Short run of mixed operations with the occasional undecoded code
  task automatic mixed_segment();
    int pick;
    repeat ($urandom_range(8, 20)) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      send_request(CMD_PUSH, random_word());
      else if (pick < 55) send_request(CMD_POP, random_word());
      else if (pick < 70) send_request(CMD_PEEK, random_word());
      else if (pick < 90) send_request(CMD_SWAP, random_word());
      else if (pick < 95) send_request(CMD_DUMP, random_word());
      else send_request(cmd_t'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD)),
                        random_word());
    end
  endtask

  initial begin
    int seg;
    sb           = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    idle_pct     = 0;
    track_depth  = 0;
    items_sent   = 0;
    quiet_cycles = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-stack errors, extreme words, swap order, dump, undecoded codes
    send_request(CMD_PEEK, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_SWAP, '0);
    send_request(CMD_DUMP, '0);
    send_request(CMD_PUSH, 32'sh7FFF_FFFF);
    send_request(CMD_SWAP, '0);
    send_request(CMD_PEEK, '0);
    send_request(CMD_PUSH, 32'sh8000_0000);
    send_request(CMD_PUSH, '0);
    send_request(CMD_PUSH, -32'sd1);
    send_request(CMD_PEEK, '0);
    send_request(CMD_SWAP, '0);
    send_request(CMD_PEEK, '0);
    send_request(CMD_DUMP, '0);
    send_request(CMD_POP, '0);
    send_unused_codes();
    send_request(CMD_PEEK, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_DUMP, '0);
    wait_drained();

    // Random: fill, drain and mixed runs, idling in phases
    seg = 0;
    while (items_sent < RUN_ITEMS) begin
      idle_pct = IDLE_PCT[(seg / 4) % 3];
      if (seg == 0) begin
        fill_segment(1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: fill_segment(1'b0);
          3, 4:    drain_segment();
          9:       send_request(CMD_DUMP, random_word());
          default: mixed_segment();
        endcase
      end
      if ($urandom_range(0, 3) == 0) send_request(CMD_DUMP, random_word());
      if (seg % 10 == 5) wait_drained();
      seg++;
    end

    wait_drained();
    if (sb.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
